### sv/sac_lfu_pkg.sv
package sac_lfu_pkg;

  localparam int MAX_WAYS   = 8;
  localparam int WAY_BITS   = 3;
  localparam int MAX_SETS   = 1024;
  localparam int SET_BITS   = 10;
  localparam int ENTRY_BITS = SET_BITS + WAY_BITS;
  localparam int COUNT_BITS = 32;
  localparam int ADDR_BITS  = 64;
  localparam int TAG_BITS   = 64;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 6;
  localparam int OUT_BITS      = 8;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_CACHE_SIZE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WAYS       = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_BLOCK_SIZE = 2'd2;

  localparam logic [5:0] CACHE_SIZE_RST = 6'd15;
  localparam logic [1:0] WAYS_RST       = 2'd2;
  localparam logic [3:0] BLOCK_SIZE_RST = 4'd5;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic                accept;
    logic                rd_en;
    logic [WAY_BITS-1:0] rd_way;
    logic                eval;
    logic                eval_first;
    logic                commit;
    logic                clr_en;
    logic [SET_BITS-1:0] clr_set;
  } dp_cmd_t;

  typedef struct packed {
    logic              out_free;
    logic [WAY_BITS:0] num_ways;
  } dp_status_t;

endpackage

### sv/sac_lfu_ctrl.sv
module sac_lfu_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  sac_lfu_pkg::dp_status_t status_i,
  output sac_lfu_pkg::dp_cmd_t    cmd_o
);

  sac_lfu_pkg::state_e state_q, state_d;
  logic [sac_lfu_pkg::WAY_BITS:0]   way_q, way_d;
  logic [sac_lfu_pkg::SET_BITS-1:0] clr_q, clr_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sac_lfu_pkg::ST_CLEAR;
      way_q   <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      way_q   <= way_d;
      clr_q   <= clr_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    way_d      = way_q;
    clr_d      = clr_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.rd_way  = way_q[sac_lfu_pkg::WAY_BITS-1:0];
    cmd_o.clr_set = clr_q;
    unique case (state_q)
      sac_lfu_pkg::ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == sac_lfu_pkg::SET_BITS'(sac_lfu_pkg::MAX_SETS - 1)) begin
          state_d = sac_lfu_pkg::ST_IDLE;
        end
      end
      sac_lfu_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        way_d        = '0;
        if (in_valid_i) begin
          state_d = sac_lfu_pkg::ST_SCAN;
        end
      end
      sac_lfu_pkg::ST_SCAN: begin
        // read way k while judging way k-1
        cmd_o.rd_en      = (way_q < status_i.num_ways);
        cmd_o.eval       = (way_q != '0);
        cmd_o.eval_first = (way_q == (sac_lfu_pkg::WAY_BITS+1)'(1));
        way_d            = way_q + 1'b1;
        if (way_q == status_i.num_ways) begin
          state_d = sac_lfu_pkg::ST_UPDATE;
        end
      end
      sac_lfu_pkg::ST_UPDATE: begin
        cmd_o.commit = status_i.out_free;
        if (status_i.out_free) begin
          state_d = sac_lfu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sac_lfu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### sv/sac_lfu_dp.sv
module sac_lfu_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sac_lfu_pkg::dp_cmd_t                   cmd_i,
  output sac_lfu_pkg::dp_status_t                status_o,
  input  logic                                   cfg_we_i,
  input  logic [sac_lfu_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [sac_lfu_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic [sac_lfu_pkg::ADDR_BITS-1:0]      in_address_i,
  input  logic                                   in_func_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [sac_lfu_pkg::OUT_BITS-1:0]       out_data_o
);

  localparam int SB = sac_lfu_pkg::SET_BITS;
  localparam int WB = sac_lfu_pkg::WAY_BITS;
  localparam int CB = sac_lfu_pkg::COUNT_BITS;
  localparam int TB = sac_lfu_pkg::TAG_BITS;
  localparam int EB = sac_lfu_pkg::ENTRY_BITS;

  // configuration
  logic [5:0] cache_size_q;
  logic [1:0] ways_q;
  logic [3:0] block_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_size_q <= sac_lfu_pkg::CACHE_SIZE_RST;
      ways_q       <= sac_lfu_pkg::WAYS_RST;
      block_q      <= sac_lfu_pkg::BLOCK_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sac_lfu_pkg::CFG_CACHE_SIZE: cache_size_q <= cfg_data_i;
        sac_lfu_pkg::CFG_WAYS:       ways_q       <= cfg_data_i[1:0];
        sac_lfu_pkg::CFG_BLOCK_SIZE: block_q      <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // address split
  logic [4:0]    sub_sum;
  logic [5:0]    idx_diff;
  logic [3:0]    nidx;
  logic [4:0]    tag_shift;
  logic [SB-1:0] set_mask;
  logic [TB-1:0] addr_off;
  logic [SB-1:0] set_d;
  logic [TB-1:0] tag_d;

  always_comb begin
    sub_sum   = {3'b000, ways_q} + {1'b0, block_q};
    idx_diff  = (cache_size_q >= {1'b0, sub_sum}) ? (cache_size_q - {1'b0, sub_sum}) : 6'd0;
    nidx      = (idx_diff > 6'(SB)) ? 4'(SB) : idx_diff[3:0];
    set_mask  = ~({SB{1'b1}} << nidx);
    addr_off  = in_address_i >> block_q;
    set_d     = addr_off[SB-1:0] & set_mask;
    tag_shift = {1'b0, block_q} + {1'b0, nidx};
    tag_d     = in_address_i >> tag_shift;
  end

  assign status_o.num_ways = (WB+1)'(1) << ways_q;

  // item registers
  logic          func_q;
  logic [SB-1:0] set_q;
  logic [TB-1:0] tag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= in_func_i;
      set_q  <= set_d;
      tag_q  <= tag_d;
    end
  end

  // stores
  logic [sac_lfu_pkg::MAX_WAYS-1:0] valid_mem [sac_lfu_pkg::MAX_SETS];
  logic [TB-1:0] tag_mem   [sac_lfu_pkg::MAX_SETS * sac_lfu_pkg::MAX_WAYS];
  logic [CB-1:0] cnt_mem   [sac_lfu_pkg::MAX_SETS * sac_lfu_pkg::MAX_WAYS];
  logic          dirty_mem [sac_lfu_pkg::MAX_SETS * sac_lfu_pkg::MAX_WAYS];

  logic [sac_lfu_pkg::MAX_WAYS-1:0] row_q;
  logic [TB-1:0] tag_rd_q;
  logic [CB-1:0] cnt_rd_q;
  logic          dirty_rd_q;
  logic [WB-1:0] rd_way_q;
  logic [EB-1:0] rd_addr;

  assign rd_addr = {set_q, cmd_i.rd_way};

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      row_q <= valid_mem[set_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      tag_rd_q   <= tag_mem[rd_addr];
      cnt_rd_q   <= cnt_mem[rd_addr];
      dirty_rd_q <= dirty_mem[rd_addr];
      rd_way_q   <= cmd_i.rd_way;
    end
  end

  // scan: first hit, first invalid, first lowest count
  logic          hit_q;
  logic          inv_q;
  logic [WB-1:0] hit_way_q;
  logic [WB-1:0] inv_way_q;
  logic [WB-1:0] min_way_q;
  logic [CB-1:0] hit_cnt_q;
  logic [CB-1:0] min_cnt_q;
  logic          min_dirty_q;
  logic          way_valid;
  logic          way_match;

  assign way_valid = row_q[rd_way_q];
  assign way_match = way_valid && (tag_rd_q == tag_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
      inv_q <= 1'b0;
    end else if (cmd_i.eval) begin
      if (cmd_i.eval_first) begin
        hit_q <= way_match;
        inv_q <= !way_valid;
      end else begin
        hit_q <= hit_q || way_match;
        inv_q <= inv_q || !way_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      if (cmd_i.eval_first || (!hit_q && way_match)) begin
        hit_way_q <= rd_way_q;
        hit_cnt_q <= cnt_rd_q;
      end
      if (cmd_i.eval_first || (!inv_q && !way_valid)) begin
        inv_way_q <= rd_way_q;
      end
      if (cmd_i.eval_first || (cnt_rd_q < min_cnt_q)) begin
        min_way_q   <= rd_way_q;
        min_cnt_q   <= cnt_rd_q;
        min_dirty_q <= dirty_rd_q;
      end
    end
  end

  // outcome
  logic [WB-1:0] vict_way;
  logic          write_back;
  logic [EB-1:0] wr_addr;
  logic [CB-1:0] hit_cnt_inc;

  always_comb begin
    if (hit_q) begin
      vict_way = hit_way_q;
    end else if (inv_q) begin
      vict_way = inv_way_q;
    end else begin
      vict_way = min_way_q;
    end
    write_back  = !hit_q && !inv_q && min_dirty_q;
    wr_addr     = {set_q, vict_way};
    hit_cnt_inc = (hit_cnt_q == sac_lfu_pkg::COUNT_MAX) ? hit_cnt_q : hit_cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_en) begin
      valid_mem[cmd_i.clr_set] <= '0;
    end else if (cmd_i.commit && !hit_q) begin
      valid_mem[set_q] <= row_q | (sac_lfu_pkg::MAX_WAYS'(1) << vict_way);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !hit_q) begin
      tag_mem[wr_addr] <= tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      cnt_mem[wr_addr] <= hit_q ? hit_cnt_inc : CB'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (!hit_q || func_q)) begin
      dirty_mem[wr_addr] <= func_q;
    end
  end

  // result register
  logic                              out_valid_q;
  logic [sac_lfu_pkg::OUT_BITS-1:0]  out_data_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {3'b000, vict_way, write_back, hit_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### sv/set_assoc_cache_lfu.sv
// Tag store of a set-associative write-back, write-allocate cache with
// least-frequently-used replacement. Each input word is one access: tuser
// carries the kind (0 read, 1 write) and tdata the 64-bit byte address. Each
// access returns one result word: hit, write-back and the way that hit or was
// filled. Set index and tag are cut from the address by the cache size,
// associativity and block size registers (write them only while the block is
// idle). Up to 1024 sets of up to 8 ways, 32-bit saturating use counts.
// After reset the block sweeps the valid bits of all 1024 sets, one set per
// cycle, with s_axis_tready low; configuration writes are taken meanwhile.
// An access runs in steps: the first latches and splits the address and
// reads the set's valid row, then the tag/count memory port walks the set
// one way per cycle (lookup and victim choice share the same pass), and a
// last step writes back the update once the result register is free. One
// access is in flight at a time; the result register lets the next access
// be taken while a result still waits on m_axis_tready.
module set_assoc_cache_lfu (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [sac_lfu_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [sac_lfu_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  // access stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [sac_lfu_pkg::ADDR_BITS-1:0]     s_axis_tdata,  // [63:0] address
  input  logic                                  s_axis_tuser,  // [0] func
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [sac_lfu_pkg::OUT_BITS-1:0]      m_axis_tdata   // [0] hit, [1] write_back,
                                                               // [4:2] way, [7:5] zero
);

  sac_lfu_pkg::dp_cmd_t    cmd;
  sac_lfu_pkg::dp_status_t status;

  sac_lfu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sac_lfu_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_address_i (s_axis_tdata),
    .in_func_i    (s_axis_tuser),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata)
  );

  // no access taken while the valid sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_en |-> !s_axis_tready)
    else $error("access accepted during valid sweep");

  // a hit never reports a write-back
  a_hit_no_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[1])
    else $error("hit with write-back");

  // reported way lies inside the configured associativity
  a_way_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |->
      ({1'b0, m_axis_tdata[4:2]} < status.num_ways))
    else $error("result way beyond associativity");

endmodule
